FILE: hw/rtl/mcpe_pkg.sv
// Package with shared types, codes and constants for the MIDI command packet encoder.
`timescale 1ns / 1ps

package mcpe_pkg;

    // Number of packet slots one command can fill
    localparam int unsigned SLOT_COUNT = 3;

    // Switch command actions
    typedef enum logic [2:0] {
        ACT_NOTE    = 3'd0,
        ACT_CTRL    = 3'd1,
        ACT_PROGRAM = 3'd2,
        ACT_BEND    = 3'd3,
        ACT_START   = 3'd4,
        ACT_STOP    = 3'd5
    } action_t;

    // USB-MIDI code index numbers
    localparam logic [3:0] CI_NOTE_OFF = 4'h8;
    localparam logic [3:0] CI_NOTE_ON  = 4'h9;
    localparam logic [3:0] CI_CTRL     = 4'hB;
    localparam logic [3:0] CI_PROG     = 4'hC;
    localparam logic [3:0] CI_BEND     = 4'hE;
    localparam logic [3:0] CI_SINGLE   = 4'hF;

    // MIDI status bytes, channel goes into the low nibble
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_CTRL     = 8'hB0;
    localparam logic [7:0] ST_PROG     = 8'hC0;
    localparam logic [7:0] ST_BEND     = 8'hE0;
    localparam logic [7:0] ST_START    = 8'hFA;
    localparam logic [7:0] ST_STOP     = 8'hFC;

    // Bank select controllers and pitch bend center
    localparam logic [6:0]  BANK_MSB_CTRL = 7'h00;
    localparam logic [6:0]  BANK_LSB_CTRL = 7'h20;
    localparam logic [13:0] BEND_CENTER   = 14'h2000;

    // Serial byte counts
    localparam logic [1:0] LEN_THREE = 2'd3;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_ONE   = 2'd1;

    // One MIDI message as a USB-MIDI event packet
    typedef struct packed {
        logic [3:0] code_index;
        logic [7:0] status_byte;
        logic [6:0] first_data;
        logic [6:0] second_data;
        logic [1:0] serial_count;
    } pkt_t;

    // Decoded command: slot 0 bank MSB, slot 1 bank LSB, slot 2 main message
    typedef struct packed {
        pkt_t [SLOT_COUNT-1:0]  slot;
        logic [SLOT_COUNT-1:0]  mask;
    } cmd_t;

    // Packet leaving the command register toward the output register
    typedef struct packed {
        pkt_t pkt;
        logic last;
    } out_pkt_t;

endpackage

FILE: hw/rtl/midi_command_packet_encoder.sv
// Top level of the MIDI command packet encoder.
`timescale 1ns / 1ps
//
// Takes one stored switch command per request on the s_ channel (valid/ready)
// and sends the MIDI messages it causes, one USB-MIDI event packet per
// request on the m_ channel, with the serial byte count and a flag on the
// final packet of the command.
// A command is decoded into up to three packet slots and held in a command
// register; while the output register is free, one packet a cycle moves from
// there into the output register, which drives m_valid.
// A command sends its packets in turn, one to three of them (program change
// with both bank bytes sends three). A command that causes no packet is
// accepted and sends nothing.
// The next command is accepted in the cycle its last packet moves to the
// output register, so commands follow back to back.
// When the receiver stalls, the output register holds its packet and the
// command register holds the rest; s_ready stays low while the command register is full.
// Reset (aresetn low, synchronous) empties both registers and drops m_valid.
//

module midi_command_packet_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_action,
    input  logic [7:0] s_channel_byte,
    input  logic [7:0] s_param_one,
    input  logic [7:0] s_param_two,
    input  logic [7:0] s_param_three,
    input  logic       s_switch_on,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_code_index,
    output logic [7:0] m_status_byte,
    output logic [6:0] m_first_data,
    output logic [6:0] m_second_data,
    output logic [1:0] m_serial_count,
    output logic       m_last_of_run
);
    import mcpe_pkg::*;

    cmd_t     dec_cmd;
    out_pkt_t pkt;
    logic     pkt_valid;
    logic     out_free;
    logic     m_valid_reg, m_valid_next;
    out_pkt_t out_reg, out_next;

    mcpe_decode u_decode (
        .action       (s_action),
        .channel_byte (s_channel_byte),
        .param_one    (s_param_one),
        .param_two    (s_param_two),
        .param_three  (s_param_three),
        .switch_on    (s_switch_on),
        .cmd          (dec_cmd)
    );

    mcpe_cmd_reg u_cmd_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req_cmd   (dec_cmd),
        .pkt_valid (pkt_valid),
        .pkt_take  (out_free),
        .pkt_out   (pkt)
    );

    // Output register takes a packet whenever it is empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (out_free) begin
            m_valid_next = pkt_valid;
            out_next     = pkt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_code_index   = out_reg.pkt.code_index;
    assign m_status_byte  = out_reg.pkt.status_byte;
    assign m_first_data   = out_reg.pkt.first_data;
    assign m_second_data  = out_reg.pkt.second_data;
    assign m_serial_count = out_reg.pkt.serial_count;
    assign m_last_of_run  = out_reg.last;

endmodule

FILE: hw/rtl/mcpe_decode.sv
// Decoder from one stored switch command to up to three packet slots.
`timescale 1ns / 1ps

module mcpe_decode (
    input  logic [2:0]   action,
    input  logic [7:0]   channel_byte,
    input  logic [7:0]   param_one,
    input  logic [7:0]   param_two,
    input  logic [7:0]   param_three,
    input  logic         switch_on,
    output mcpe_pkg::cmd_t cmd
);
    import mcpe_pkg::*;

    logic [7:0] chan;
    pkt_t       pkt_none;

    assign chan     = {4'h0, channel_byte[3:0]};
    assign pkt_none = '0;

    // Build the slots and the mask of slots to send
    always_comb begin
        cmd.slot = {pkt_none, pkt_none, pkt_none};
        cmd.mask = '0;
        unique case (action)
            ACT_NOTE: begin
                cmd.mask[2] = 1'b1;
                if (switch_on) begin
                    cmd.slot[2] = '{CI_NOTE_ON, ST_NOTE_ON | chan, param_one[6:0],
                                    param_two[6:0], LEN_THREE};
                end else begin
                    cmd.slot[2] = '{CI_NOTE_OFF, ST_NOTE_OFF | chan, param_one[6:0],
                                    7'd0, LEN_THREE};
                end
            end
            ACT_CTRL: begin
                // drop the off message when no off value is stored
                cmd.mask[2] = switch_on || !param_three[7];
                cmd.slot[2] = '{CI_CTRL, ST_CTRL | chan, param_one[6:0],
                                switch_on ? param_two[6:0] : param_three[6:0],
                                LEN_THREE};
            end
            ACT_PROGRAM: begin
                cmd.mask[0] = !param_two[7];
                cmd.mask[1] = !param_three[7];
                cmd.mask[2] = 1'b1;
                cmd.slot[0] = '{CI_CTRL, ST_CTRL | chan, BANK_MSB_CTRL,
                                param_two[6:0], LEN_THREE};
                cmd.slot[1] = '{CI_CTRL, ST_CTRL | chan, BANK_LSB_CTRL,
                                param_three[6:0], LEN_THREE};
                cmd.slot[2] = '{CI_PROG, ST_PROG | chan, param_one[6:0],
                                7'd0, LEN_TWO};
            end
            ACT_BEND: begin
                cmd.mask[2] = 1'b1;
                if (switch_on) begin
                    cmd.slot[2] = '{CI_BEND, ST_BEND | chan, param_one[6:0],
                                    param_two[6:0], LEN_THREE};
                end else begin
                    cmd.slot[2] = '{CI_BEND, ST_BEND | chan, BEND_CENTER[6:0],
                                    BEND_CENTER[13:7], LEN_THREE};
                end
            end
            ACT_START: begin
                cmd.mask[2] = 1'b1;
                cmd.slot[2] = '{CI_SINGLE, ST_START, 7'd0, 7'd0, LEN_ONE};
            end
            ACT_STOP: begin
                cmd.mask[2] = 1'b1;
                cmd.slot[2] = '{CI_SINGLE, ST_STOP, 7'd0, 7'd0, LEN_ONE};
            end
            default: begin
                cmd.mask = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/mcpe_cmd_reg.sv
// Command register that hands out its pending packets one per cycle while they are taken.
`timescale 1ns / 1ps

module mcpe_cmd_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               req_valid,
    output logic               req_ready,
    input  mcpe_pkg::cmd_t     req_cmd,
    output logic               pkt_valid,
    input  logic               pkt_take,
    output mcpe_pkg::out_pkt_t pkt_out
);
    import mcpe_pkg::*;

    logic                  cmd_valid_reg, cmd_valid_next;
    logic [SLOT_COUNT-1:0] mask_reg, mask_next;
    pkt_t [SLOT_COUNT-1:0] slot_reg, slot_next;
    logic [SLOT_COUNT-1:0] sel;
    logic [SLOT_COUNT-1:0] remain;
    logic                  take;
    logic                  accept;

    // Pick the lowest pending slot
    always_comb begin
        priority if (mask_reg[0]) begin
            sel = 3'b001;
        end else if (mask_reg[1]) begin
            sel = 3'b010;
        end else begin
            sel = 3'b100;
        end
    end

    always_comb begin
        priority if (sel[0]) begin
            pkt_out.pkt = slot_reg[0];
        end else if (sel[1]) begin
            pkt_out.pkt = slot_reg[1];
        end else begin
            pkt_out.pkt = slot_reg[2];
        end
    end

    assign remain       = mask_reg & ~sel;
    assign pkt_out.last = (remain == '0);
    assign pkt_valid    = cmd_valid_reg;
    assign take         = cmd_valid_reg && pkt_take;

    // Free for a new request when empty or once the last packet leaves
    assign req_ready = !cmd_valid_reg || (take && remain == '0);
    assign accept    = req_valid && req_ready;

    // Load a new request or advance through the pending slots
    always_comb begin
        cmd_valid_next = cmd_valid_reg;
        mask_next      = mask_reg;
        slot_next      = slot_reg;
        if (accept) begin
            cmd_valid_next = |req_cmd.mask;
            mask_next      = req_cmd.mask;
            slot_next      = req_cmd.slot;
        end else if (take) begin
            cmd_valid_next = |remain;
            mask_next      = remain;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
            mask_reg      <= mask_next;
        end
        slot_reg <= slot_next;
    end

    // A held command always has a packet left to send
    a_mask_live: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid_reg |-> (mask_reg != '0))
        else $error("command held with empty mask");

    // Ready while busy only when the final packet is leaving
    a_ready_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_valid_reg && req_ready) |-> (pkt_take && $countones(mask_reg) == 1))
        else $error("ready raised before last packet left");

    // A partly sent command stays for its remaining packets
    a_keep_rest: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && remain != '0) |=> (cmd_valid_reg && mask_reg == $past(remain)))
        else $error("remaining packets lost");

    // Exactly one slot selected while busy
    a_sel_one: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid_reg |-> $onehot(sel & mask_reg))
        else $error("slot selection not one-hot");

endmodule
